/* rtl/core/uart_rb_pkg.sv */
// ----------------------------------------------------------------------------
// UART ring buffer package
// Command codes, field widths and the pending-stage record shared by the
// buffered UART data path.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CMD_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LINE_RX  = 3'd0,
        CMD_TX_EMPTY = 3'd1,
        CMD_QUEUE_TX = 3'd2,
        CMD_READ_RX  = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_t;

    // Which store the pending transfer takes its byte from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_RX   = 2'd1,
        SRC_TX   = 2'd2
    } src_t;

    // Result of one command, waiting for the store read data
    typedef struct packed {
        src_t src;
        logic accepted;
        logic rx_has_data;
        logic rx_drop_flag;
        logic tx_refuse_flag;
        logic send_request;
    } pend_t;

endpackage

/* rtl/core/uart_rb_ram.sv */
// ----------------------------------------------------------------------------
// UART ring buffer RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uart_rb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/uart_rx_tx_ring_buffers.sv */
// ----------------------------------------------------------------------------
// UART receive and transmit ring buffers
// Two ring queues with sticky overflow flags and a transmit send request.
// ----------------------------------------------------------------------------
// One command is taken per s_ transfer and gives exactly one m_ transfer.
// Pointers, flags and the send request update at the input transfer; the
// byte, if any, comes from a registered RAM read and then passes the
// output register, whose load raises m_tvalid; the result then holds there
// while m_tready is low, as may the pending stage before it. A new command
// may be taken every cycle while the output side keeps up. Each queue holds
// at most DEPTH-1 bytes. A line byte that finds the receive queue full is
// dropped and sets the receive overflow flag; a transmit byte that finds its
// queue full is refused and sets the transmit overflow flag. Command 4 clears
// both flags. Command 1 (transmitter empty) sends the oldest queued byte or,
// when the queue is empty, clears the send request. The stores need no
// clearing after reset.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
    parameter int unsigned RX_DEPTH = 64,
    parameter int unsigned TX_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_in
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_out, [8] accepted, [9] rx_has_data,
                                   // [10] receive drop flag, [11] transmit refuse flag,
                                   // [12] send_request, [15:13] zero
    output logic        m_tuser    // [0] data_valid
);

    localparam int unsigned RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // Queue pointers and flags
    logic [RX_AW-1:0] rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [TX_AW-1:0] tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic             rx_ovf_reg, rx_ovf_next;
    logic             tx_ovf_reg, tx_ovf_next;
    logic             send_reg, send_next;

    // Pending stage and output register
    logic                 p_valid_reg;
    uart_rb_pkg::pend_t   p_reg, p_next;
    logic                 out_valid_reg;
    logic [15:0]          out_data_reg;
    logic                 out_dv_reg;
    logic                 out_load;
    logic                 s_fire;

    // RAM ports
    logic                              rx_we, rx_re, tx_we, tx_re;
    logic [uart_rb_pkg::BYTE_W-1:0]    rx_rdata, tx_rdata, byte_sel;
    logic [RX_AW-1:0]                  rx_wr_inc, rx_rd_inc;
    logic [TX_AW-1:0]                  tx_wr_inc, tx_rd_inc;
    uart_rb_pkg::cmd_t                 cmd;

    assign cmd      = uart_rb_pkg::cmd_t'(s_tuser);
    assign out_load = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p_valid_reg || out_load;
    assign s_fire   = s_tvalid && s_tready;

    // Wrapping pointer increments
    assign rx_wr_inc = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;
    assign tx_wr_inc = (tx_wr_reg == TX_LAST) ? '0 : tx_wr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_reg == TX_LAST) ? '0 : tx_rd_reg + 1'b1;

    // Decode the command and update the queue state
    always_comb begin
        rx_wr_next  = rx_wr_reg;
        rx_rd_next  = rx_rd_reg;
        tx_wr_next  = tx_wr_reg;
        tx_rd_next  = tx_rd_reg;
        rx_ovf_next = rx_ovf_reg;
        tx_ovf_next = tx_ovf_reg;
        send_next   = send_reg;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        p_next.src      = uart_rb_pkg::SRC_NONE;
        p_next.accepted = 1'b0;
        if (s_fire) begin
            case (cmd)
                uart_rb_pkg::CMD_LINE_RX: begin
                    if (rx_wr_inc == rx_rd_reg) begin
                        rx_ovf_next = 1'b1;
                    end else begin
                        rx_we           = 1'b1;
                        rx_wr_next      = rx_wr_inc;
                        p_next.accepted = 1'b1;
                    end
                end
                uart_rb_pkg::CMD_TX_EMPTY: begin
                    if (tx_rd_reg == tx_wr_reg) begin
                        send_next = 1'b0;
                    end else begin
                        tx_re      = 1'b1;
                        tx_rd_next = tx_rd_inc;
                        p_next.src = uart_rb_pkg::SRC_TX;
                    end
                end
                uart_rb_pkg::CMD_QUEUE_TX: begin
                    if (tx_wr_inc == tx_rd_reg) begin
                        tx_ovf_next = 1'b1;
                    end else begin
                        tx_we           = 1'b1;
                        tx_wr_next      = tx_wr_inc;
                        send_next       = 1'b1;
                        p_next.accepted = 1'b1;
                    end
                end
                uart_rb_pkg::CMD_READ_RX: begin
                    if (rx_wr_reg != rx_rd_reg) begin
                        rx_re      = 1'b1;
                        rx_rd_next = rx_rd_inc;
                        p_next.src = uart_rb_pkg::SRC_RX;
                    end
                end
                uart_rb_pkg::CMD_CLEAR: begin
                    rx_ovf_next = 1'b0;
                    tx_ovf_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
        p_next.rx_has_data    = (rx_wr_next != rx_rd_next);
        p_next.rx_drop_flag   = rx_ovf_next;
        p_next.tx_refuse_flag = tx_ovf_next;
        p_next.send_request   = send_next;
    end

    // Queue state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_reg  <= '0;
            rx_rd_reg  <= '0;
            tx_wr_reg  <= '0;
            tx_rd_reg  <= '0;
            rx_ovf_reg <= 1'b0;
            tx_ovf_reg <= 1'b0;
            send_reg   <= 1'b0;
        end else begin
            rx_wr_reg  <= rx_wr_next;
            rx_rd_reg  <= rx_rd_next;
            tx_wr_reg  <= tx_wr_next;
            tx_rd_reg  <= tx_rd_next;
            rx_ovf_reg <= rx_ovf_next;
            tx_ovf_reg <= tx_ovf_next;
            send_reg   <= send_next;
        end
    end

    // Hold the pending result while the RAM read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_fire) begin
            p_valid_reg <= 1'b1;
        end else if (out_load) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p_reg <= p_next;
        end
    end

    // Select the byte read for this result
    always_comb begin
        case (p_reg.src)
            uart_rb_pkg::SRC_RX: byte_sel = rx_rdata;
            uart_rb_pkg::SRC_TX: byte_sel = tx_rdata;
            default:             byte_sel = '0;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {3'b000, p_reg.send_request, p_reg.tx_refuse_flag,
                             p_reg.rx_drop_flag, p_reg.rx_has_data, p_reg.accepted,
                             byte_sel};
            out_dv_reg   <= (p_reg.src != uart_rb_pkg::SRC_NONE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_dv_reg;

    // Receive and transmit stores
    uart_rb_ram #(
        .WIDTH (uart_rb_pkg::BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (s_tdata),
        .re    (rx_re),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    uart_rb_ram #(
        .WIDTH (uart_rb_pkg::BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_wr_reg),
        .wdata (s_tdata),
        .re    (tx_re),
        .raddr (tx_rd_reg),
        .rdata (tx_rdata)
    );

`ifndef SYNTHESIS
    // Command side stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (p_valid_reg && m_tvalid && !m_tready))
        else $error("command side stalled without a blocked result");

    // A pending result is held until it moves to the output
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && !out_load) |=> (p_valid_reg && $stable(p_reg)))
        else $error("pending result changed while stalled");

    // A byte taken from a queue never coincides with a stored byte
    a_dv_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[8])
        else $error("data_valid and accepted both set");

    // No byte is reported without data_valid
    a_dout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'h00))
        else $error("data_out nonzero without data_valid");

    // Pop never issued on an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!rx_re || (rx_wr_reg != rx_rd_reg)) && (!tx_re || (tx_wr_reg != tx_rd_reg)))
        else $error("store read issued on an empty queue");
`endif

endmodule
